@@ src/mmts_pkg.sv @@
// ----------------------------------------------------------------------------
// mmts_pkg
// Types, codes and functions shared by the token scanner modules: the
// tokenizer automaton, the keyword table and the token bookkeeping.
// ----------------------------------------------------------------------------
package mmts_pkg;

    localparam int KW_MAX_LEN = 7;
    localparam int PREFIX_W   = 8 * KW_MAX_LEN;
    localparam int KW_COUNT   = 10;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [7:0]  TOK_LEN_MAX = 8'd255;
    localparam logic [34:0] NUM_MAX     = 35'd2147483647;

    // Token kinds and automaton states share one code space.
    localparam logic [5:0] K_ID      = 6'd0;
    localparam logic [5:0] K_NUM     = 6'd1;
    localparam logic [5:0] K_INT     = 6'd2;
    localparam logic [5:0] K_WAIN    = 6'd3;
    localparam logic [5:0] K_IF      = 6'd4;
    localparam logic [5:0] K_ELSE    = 6'd5;
    localparam logic [5:0] K_WHILE   = 6'd6;
    localparam logic [5:0] K_PRINTLN = 6'd7;
    localparam logic [5:0] K_RETURN  = 6'd8;
    localparam logic [5:0] K_NEW     = 6'd9;
    localparam logic [5:0] K_DELETE  = 6'd10;
    localparam logic [5:0] K_NULL    = 6'd11;
    localparam logic [5:0] K_LPAREN  = 6'd12;
    localparam logic [5:0] K_RPAREN  = 6'd13;
    localparam logic [5:0] K_LBRACE  = 6'd14;
    localparam logic [5:0] K_RBRACE  = 6'd15;
    localparam logic [5:0] K_LBRACK  = 6'd16;
    localparam logic [5:0] K_RBRACK  = 6'd17;
    localparam logic [5:0] K_BECOMES = 6'd18;
    localparam logic [5:0] K_PLUS    = 6'd19;
    localparam logic [5:0] K_MINUS   = 6'd20;
    localparam logic [5:0] K_STAR    = 6'd21;
    localparam logic [5:0] K_SLASH   = 6'd22;
    localparam logic [5:0] K_PCT     = 6'd23;
    localparam logic [5:0] K_AMP     = 6'd24;
    localparam logic [5:0] K_COMMA   = 6'd25;
    localparam logic [5:0] K_SEMI    = 6'd26;
    localparam logic [5:0] K_LT      = 6'd27;
    localparam logic [5:0] K_GT      = 6'd28;
    localparam logic [5:0] K_LE      = 6'd29;
    localparam logic [5:0] K_GE      = 6'd30;
    localparam logic [5:0] K_NE      = 6'd31;
    localparam logic [5:0] K_EQ      = 6'd32;
    localparam logic [5:0] S_START   = 6'd33;
    localparam logic [5:0] S_WS      = 6'd34;
    localparam logic [5:0] S_COMMENT = 6'd35;
    localparam logic [5:0] S_EXCL    = 6'd36;
    localparam logic [5:0] S_NONE    = 6'd63;

    localparam logic [2:0] E_NONE     = 3'd0;
    localparam logic [2:0] E_NO_TRANS = 3'd1;
    localparam logic [2:0] E_RANGE    = 3'd2;
    localparam logic [2:0] E_LEAD_0   = 3'd3;
    localparam logic [2:0] E_EOL      = 3'd4;

    // Keyword text, first character in the lowest byte.
    localparam logic [PREFIX_W-1:0] KW_TEXT [KW_COUNT] = '{
        PREFIX_W'(56'h746E69),         PREFIX_W'(56'h6E696177),
        PREFIX_W'(56'h6669),           PREFIX_W'(56'h65736C65),
        PREFIX_W'(56'h656C696877),     PREFIX_W'(56'h6E6C746E697270),
        PREFIX_W'(56'h6E7275746572),   PREFIX_W'(56'h77656E),
        PREFIX_W'(56'h6574656C6564),   PREFIX_W'(56'h4C4C554E)
    };
    localparam logic [7:0] KW_LEN [KW_COUNT] = '{
        8'd3, 8'd4, 8'd2, 8'd4, 8'd5, 8'd7, 8'd6, 8'd3, 8'd6, 8'd4
    };
    localparam logic [5:0] KW_KIND [KW_COUNT] = '{
        K_INT, K_WAIN, K_IF, K_ELSE, K_WHILE,
        K_PRINTLN, K_RETURN, K_NEW, K_DELETE, K_NULL
    };

    typedef struct packed {
        logic [5:0]          state;
        logic [PREFIX_W-1:0] prefix;
        logic [7:0]          len;
        logic [30:0]         accum;
        logic                ovf;
    } t_tok;

    typedef struct packed {
        logic [5:0]  kind;
        logic [30:0] num_value;
        logic [7:0]  token_length;
        logic [2:0]  error_code;
    } t_res;

    typedef struct packed {
        logic vld;
        t_res res;
    } t_emit;

    typedef struct packed {
        logic two;
        t_res r0;
        t_res r1;
    } t_pkt;

    typedef struct packed {
        logic push;
        t_pkt pkt;
    } t_push;

    localparam t_tok TOK_CLEAR = '{state: S_START, prefix: '0, len: '0, accum: '0, ovf: 1'b0};

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A;
    endfunction

    function automatic logic is_accepting(input logic [5:0] st);
        return st != S_START && st != S_EXCL && st != S_NONE;
    endfunction

    function automatic logic [5:0] start_next(input logic [7:0] c);
        logic [5:0] r;
        if (is_digit(c)) begin
            r = K_NUM;
        end else if (is_alpha(c)) begin
            r = K_ID;
        end else if (is_space(c)) begin
            r = S_WS;
        end else begin
            unique case (c)
                "(":     r = K_LPAREN;
                ")":     r = K_RPAREN;
                "{":     r = K_LBRACE;
                "}":     r = K_RBRACE;
                "[":     r = K_LBRACK;
                "]":     r = K_RBRACK;
                "=":     r = K_BECOMES;
                "+":     r = K_PLUS;
                "-":     r = K_MINUS;
                "*":     r = K_STAR;
                "/":     r = K_SLASH;
                "%":     r = K_PCT;
                "&":     r = K_AMP;
                ",":     r = K_COMMA;
                ";":     r = K_SEMI;
                "<":     r = K_LT;
                ">":     r = K_GT;
                "!":     r = S_EXCL;
                default: r = S_NONE;
            endcase
        end
        return r;
    endfunction

    function automatic logic [5:0] lx_next(input logic [5:0] st, input logic [7:0] c);
        logic [5:0] r;
        unique case (st)
            S_START:   r = start_next(c);
            K_NUM:     r = is_digit(c) ? K_NUM : S_NONE;
            K_ID:      r = (is_alpha(c) || is_digit(c)) ? K_ID : S_NONE;
            K_BECOMES: r = (c == "=") ? K_EQ : S_NONE;
            K_LT:      r = (c == "=") ? K_LE : S_NONE;
            K_GT:      r = (c == "=") ? K_GE : S_NONE;
            S_EXCL:    r = (c == "=") ? K_NE : S_NONE;
            S_WS:      r = is_space(c) ? S_WS : S_NONE;
            K_SLASH:   r = (c == "/") ? S_COMMENT : S_NONE;
            S_COMMENT: r = (!c[7] && c != 8'h0A && c != 8'h0D) ? S_COMMENT : S_NONE;
            default:   r = S_NONE;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] kw_kind(input logic [PREFIX_W-1:0] prefix,
                                           input logic [7:0] len);
        logic [5:0] r;
        r = K_ID;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (KW_LEN[i] == len && KW_LEN[i] <= 8'(KW_MAX_LEN) && KW_TEXT[i] == prefix) begin
                r = KW_KIND[i];
            end
        end
        return r;
    endfunction

    function automatic t_tok tok_consume(input t_tok t, input logic [5:0] nx,
                                         input logic [7:0] c);
        t_tok        r;
        logic [34:0] v;
        r = t;
        for (int i = 0; i < KW_MAX_LEN; i++) begin
            if (t.len == 8'(i)) begin
                r.prefix[8*i +: 8] = c;
            end
        end
        if (t.len < TOK_LEN_MAX) begin
            r.len = t.len + 8'd1;
        end
        v = {1'b0, t.accum, 3'b000} + {3'b000, t.accum, 1'b0} + 35'(c[3:0]);
        if (nx == K_NUM && !t.ovf) begin
            if (v > NUM_MAX) begin
                r.ovf = 1'b1;
            end else begin
                r.accum = v[30:0];
            end
        end
        r.state = nx;
        return r;
    endfunction

    function automatic t_emit err_emit(input logic [2:0] code);
        t_emit e;
        e = '0;
        e.vld = 1'b1;
        e.res.error_code = code;
        return e;
    endfunction

    function automatic t_emit tok_emit(input t_tok t);
        t_emit e;
        e = '0;
        e.vld = 1'b1;
        if (t.state inside {S_WS, S_COMMENT}) begin
            e.vld = 1'b0;
        end else if (t.state == K_NUM) begin
            if (t.ovf) begin
                e = err_emit(E_RANGE);
            end else if (t.len > 8'd1 && t.prefix[7:0] == "0") begin
                e = err_emit(E_LEAD_0);
            end else begin
                e.res.kind         = K_NUM;
                e.res.num_value    = t.accum;
                e.res.token_length = t.len;
            end
        end else begin
            e.res.kind         = (t.state == K_ID) ? kw_kind(t.prefix, t.len) : t.state;
            e.res.token_length = t.len;
        end
        return e;
    endfunction

endpackage

@@ src/mmts_in_if.sv @@
// ----------------------------------------------------------------------------
// mmts_in_if
// Source byte channel: one word per source byte with its line-end flag.
// ----------------------------------------------------------------------------
interface mmts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       line_end;

    modport source (output valid, output ch, output line_end, input ready);
    modport sink (input valid, input ch, input line_end, output ready);
endinterface

@@ src/mmts_out_if.sv @@
// ----------------------------------------------------------------------------
// mmts_out_if
// Token channel: one word per token or error result.
// ----------------------------------------------------------------------------
interface mmts_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  kind;
    logic [30:0] num_value;
    logic [7:0]  token_length;
    logic [2:0]  error_code;
    logic        last;

    modport source (output valid, output kind, output num_value, output token_length,
                    output error_code, output last, input ready);
    modport sink (input valid, input kind, input num_value, input token_length,
                  input error_code, input last, output ready);
endinterface

@@ src/mmts_front.sv @@
// ----------------------------------------------------------------------------
// mmts_front
// Scanner front end: until an error, steps the tokenizer automaton once per
// accepted byte and packs its zero, one or two results into one queue word.
// ----------------------------------------------------------------------------
module mmts_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_ch,
    input  logic            i_line_end,
    input  logic            i_full,
    output logic            o_ready,
    output mmts_pkg::t_push o_push
);
    import mmts_pkg::*;

    t_tok  r_tok;
    t_tok  n_tok;
    logic  r_halted;
    logic  n_halted;
    logic  accept;
    logic  [5:0] nx;
    logic  [5:0] nx_restart;
    t_tok  tok_a;
    t_tok  tok_b;
    t_emit emit_old;
    t_emit emit_a;
    t_emit emit_b;
    t_emit res_a;
    t_emit res_b;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    assign nx         = lx_next(r_tok.state, i_ch);
    assign nx_restart = start_next(i_ch);
    assign tok_a      = tok_consume(r_tok, nx, i_ch);
    assign tok_b      = tok_consume(TOK_CLEAR, nx_restart, i_ch);
    assign emit_old   = tok_emit(r_tok);
    assign emit_a     = tok_emit(tok_a);
    assign emit_b     = tok_emit(tok_b);

    always_comb begin
        res_a = '0;
        res_b = '0;
        n_tok = r_tok;
        if (nx != S_NONE) begin
            n_tok = tok_a;
            if (i_line_end) begin
                n_tok = TOK_CLEAR;
                res_b = is_accepting(tok_a.state) ? emit_a : err_emit(E_EOL);
            end
        end else if (!is_accepting(r_tok.state)) begin
            res_b = err_emit(E_NO_TRANS);
        end else if (emit_old.vld && emit_old.res.error_code != E_NONE) begin
            res_b = emit_old;
        end else begin
            res_a = emit_old;
            if (nx_restart == S_NONE) begin
                res_b = err_emit(E_NO_TRANS);
            end else begin
                n_tok = tok_b;
                if (i_line_end) begin
                    n_tok = TOK_CLEAR;
                    res_b = is_accepting(tok_b.state) ? emit_b : err_emit(E_EOL);
                end
            end
        end
        n_halted = res_b.vld && res_b.res.error_code != E_NONE;
    end

    always_comb begin
        o_push.push   = accept && !r_halted && (res_a.vld || res_b.vld);
        o_push.pkt.two = res_a.vld && res_b.vld;
        o_push.pkt.r0  = res_a.vld ? res_a.res : res_b.res;
        o_push.pkt.r1  = res_b.res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok    <= TOK_CLEAR;
            r_halted <= 1'b0;
        end else if (accept && !r_halted) begin
            r_tok    <= n_tok;
            r_halted <= n_halted;
        end
    end

endmodule

@@ src/mmts_fifo.sv @@
// ----------------------------------------------------------------------------
// mmts_fifo
// Short queue of result words between the scanner front end and the output
// stage.
// ----------------------------------------------------------------------------
module mmts_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mmts_pkg::t_push i_push,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output mmts_pkg::t_pkt  o_head
);
    import mmts_pkg::*;

    t_pkt               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp;
    logic [FIFO_AW-1:0] r_rp;
    logic [FIFO_AW:0]   r_cnt;
    logic               do_pop;

    assign o_full  = r_cnt == (FIFO_AW+1)'(FIFO_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_head  = r_mem[r_rp];
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wp] <= i_push.pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push.push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push.push && do_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ src/mmts_back.sv @@
// ----------------------------------------------------------------------------
// mmts_back
// Output stage: takes queue words apart into single results and holds each in
// the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module mmts_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  mmts_pkg::t_pkt i_head,
    output logic           o_pop,
    mmts_out_if.source     o_out
);
    import mmts_pkg::*;

    logic r_valid;
    logic r_sel;
    t_res r_res;
    logic r_last;
    logic load;
    logic final_res;

    assign load      = !i_empty && (!r_valid || o_out.ready);
    assign final_res = !i_head.two || r_sel;
    assign o_pop     = load && final_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_sel   <= !final_res;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res  <= r_sel ? i_head.r1 : i_head.r0;
            r_last <= final_res;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.kind         = r_res.kind;
    assign o_out.num_value    = r_res.num_value;
    assign o_out.token_length = r_res.token_length;
    assign o_out.error_code   = r_res.error_code;
    assign o_out.last         = r_last;

endmodule

@@ src/maximal_munch_token_scanner.sv @@
// ----------------------------------------------------------------------------
// maximal_munch_token_scanner
// Maximal-munch tokenizer: source bytes in, token kind, value and length out.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one word per source byte with a flag on the last
// byte of each line. The output channel carries one word per token or error,
// with last set on the final word caused by a byte; a byte causes zero, one
// or two words. Whitespace and comments cause none.
// Each result passes through the queue and then the output register. One
// byte is taken every cycle while the queue is not full; a byte with two
// results fills the output register with one result after the other.
// A four-word queue sits between the automaton and the output register, so
// when the receiver stalls the scanner keeps taking bytes until the queue is
// full, and ready drops only then.
// After an error word the scanner takes bytes but gives no further words
// until reset. Reset returns the automaton to its start state, clears the
// error and empties the queue and the output register.
// ----------------------------------------------------------------------------
module maximal_munch_token_scanner (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mmts_in_if.sink    i_in,
    mmts_out_if.source o_out
);
    import mmts_pkg::*;

    t_push push;
    t_pkt  head;
    logic  full;
    logic  empty;
    logic  pop;

    mmts_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in.valid),
        .i_ch       (i_in.ch),
        .i_line_end (i_in.line_end),
        .i_full     (full),
        .o_ready    (i_in.ready),
        .o_push     (push)
    );

    mmts_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    mmts_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

@@ test/token_scan_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// token_scan_tb_pkg
// Token prediction and checking for the maximal-munch token scanner bench.
// Every source byte taken by the scanner is run through an independent model
// of the tokenizer automaton. The words it should produce are queued here and
// compared, field by field, with the words the scanner really delivers.
// ----------------------------------------------------------------------------
package token_scan_tb_pkg;

    import mmts_pkg::*;

    typedef struct packed {
        logic [5:0]  kind;
        logic [30:0] value;
        logic [7:0]  length;
        logic [2:0]  code;
        logic        last;
    } t_token_word;

    class token_checker;

        t_token_word pending_tokens [$];
        int unsigned mismatches;

        logic [5:0]          lx_state;
        logic [PREFIX_W-1:0] head_bytes;
        logic [7:0]          text_len;
        logic [31:0]         value_acc;
        logic                too_big;
        logic                stopped;
        t_token_word         step_words [$];

        string kw_spell [10] = '{"int", "wain", "if", "else", "while",
                                 "println", "return", "new", "delete", "NULL"};
        logic [5:0] kw_code [10] = '{K_INT, K_WAIN, K_IF, K_ELSE, K_WHILE,
                                     K_PRINTLN, K_RETURN, K_NEW, K_DELETE, K_NULL};

        function new();
            restart_token();
            stopped    = 1'b0;
            mismatches = 0;
        endfunction

        function void restart_token();
            lx_state   = S_START;
            head_bytes = '0;
            text_len   = '0;
            value_acc  = '0;
            too_big    = 1'b0;
        endfunction

        function logic [5:0] advance(logic [5:0] st, logic [7:0] c);
            bit digit;
            bit letter;
            bit blank;
            digit  = c >= 8'h30 && c <= 8'h39;
            letter = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
            blank  = c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A;
            case (st)
                S_START: begin
                    if (digit) return K_NUM;
                    if (letter) return K_ID;
                    if (blank) return S_WS;
                    case (c)
                        "(":     return K_LPAREN;
                        ")":     return K_RPAREN;
                        "{":     return K_LBRACE;
                        "}":     return K_RBRACE;
                        "[":     return K_LBRACK;
                        "]":     return K_RBRACK;
                        "=":     return K_BECOMES;
                        "+":     return K_PLUS;
                        "-":     return K_MINUS;
                        "*":     return K_STAR;
                        "/":     return K_SLASH;
                        "%":     return K_PCT;
                        "&":     return K_AMP;
                        ",":     return K_COMMA;
                        ";":     return K_SEMI;
                        "<":     return K_LT;
                        ">":     return K_GT;
                        "!":     return S_EXCL;
                        default: return S_NONE;
                    endcase
                end
                K_NUM:     return digit ? K_NUM : S_NONE;
                K_ID:      return (digit || letter) ? K_ID : S_NONE;
                K_BECOMES: return (c == "=") ? K_EQ : S_NONE;
                K_LT:      return (c == "=") ? K_LE : S_NONE;
                K_GT:      return (c == "=") ? K_GE : S_NONE;
                S_EXCL:    return (c == "=") ? K_NE : S_NONE;
                S_WS:      return blank ? S_WS : S_NONE;
                K_SLASH:   return (c == "/") ? S_COMMENT : S_NONE;
                S_COMMENT: return (c < 8'h80 && c != 8'h0A && c != 8'h0D) ? S_COMMENT : S_NONE;
                default:   return S_NONE;
            endcase
        endfunction

        function bit accepting(logic [5:0] st);
            return st != S_START && st != S_EXCL && st != S_NONE;
        endfunction

        function void push_word(logic [5:0] kind, logic [30:0] value, logic [7:0] length,
                                logic [2:0] code);
            step_words.insert(step_words.size(), '{kind, value, length, code, 1'b0});
        endfunction

        function void fail_step(logic [2:0] code);
            push_word(K_ID, '0, '0, code);
            stopped = 1'b1;
        endfunction

        function logic [5:0] keyword_of();
            logic [PREFIX_W-1:0] spelled;
            int                  n;
            for (int i = 0; i < 10; i++) begin
                n = kw_spell[i].len();
                if (n == text_len && n <= KW_MAX_LEN) begin
                    spelled = '0;
                    for (int j = 0; j < n; j++) begin
                        spelled[8*j +: 8] = kw_spell[i][j];
                    end
                    if (spelled == head_bytes) return kw_code[i];
                end
            end
            return K_ID;
        endfunction

        function void flush_token();
            if (lx_state == S_WS || lx_state == S_COMMENT) return;
            if (lx_state == K_NUM) begin
                if (too_big) begin
                    fail_step(E_RANGE);
                end else if (text_len > 8'd1 && head_bytes[7:0] == "0") begin
                    fail_step(E_LEAD_0);
                end else begin
                    push_word(K_NUM, value_acc[30:0], text_len, E_NONE);
                end
            end else begin
                push_word((lx_state == K_ID) ? keyword_of() : lx_state, '0, text_len, E_NONE);
            end
        endfunction

        function void absorb(logic [5:0] nx, logic [7:0] c);
            longint unsigned v;
            if (text_len < KW_MAX_LEN) begin
                head_bytes[8*text_len +: 8] = c;
            end
            if (text_len < TOK_LEN_MAX) begin
                text_len = text_len + 8'd1;
            end
            if (nx == K_NUM && !too_big) begin
                v = longint'(value_acc) * 10 + (c - 8'h30);
                if (v > 64'd2147483647) begin
                    too_big = 1'b1;
                end else begin
                    value_acc = v[31:0];
                end
            end
            lx_state = nx;
        endfunction

        function void note_byte(logic [7:0] c, logic eol);
            logic [5:0] nx;
            if (stopped) return;
            step_words.delete();
            nx = advance(lx_state, c);
            if (nx == S_NONE) begin
                if (!accepting(lx_state)) begin
                    fail_step(E_NO_TRANS);
                end else begin
                    flush_token();
                    if (!stopped) begin
                        restart_token();
                        nx = advance(S_START, c);
                        if (nx == S_NONE) fail_step(E_NO_TRANS);
                    end
                end
            end
            if (!stopped) begin
                absorb(nx, c);
                if (eol) begin
                    if (accepting(lx_state)) begin
                        flush_token();
                        if (!stopped) restart_token();
                    end else begin
                        fail_step(E_EOL);
                    end
                end
            end
            if (step_words.size() > 0) begin
                step_words[step_words.size() - 1].last = 1'b1;
                foreach (step_words[i]) begin
                    pending_tokens.insert(pending_tokens.size(), step_words[i]);
                end
            end
        endfunction

        function void compare_field(string what, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                mismatches++;
                $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
            end
        endfunction

        function void check_token(t_token_word got);
            t_token_word want;
            if (pending_tokens.size() == 0) begin
                mismatches++;
                $display("%0t: word with no token due: kind %0d, error code %0d",
                         $time, got.kind, got.code);
                return;
            end
            want = pending_tokens.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("num_value", want.value, got.value);
            compare_field("token_length", want.length, got.length);
            compare_field("error_code", want.code, got.code);
            compare_field("last", want.last, got.last);
        endfunction

    endclass

endpackage

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Bench for the maximal-munch token scanner. A short hand-written program is
// followed by a random token stream with keywords, near keywords, numbers,
// operators, whitespace, comments and long identifiers, then one error case
// and some noise that must give no words. The sender works in bursts, the
// receiver stalls in changing patterns and twice holds off for a long time.
// ----------------------------------------------------------------------------
module tb_top;

    import mmts_pkg::*;
    import token_scan_tb_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       eol;
    } t_src_byte;

    typedef enum {RX_OPEN, RX_COIN, RX_THIRD, RX_RARE} t_rx_mode;

    typedef enum {
        FAULT_START, FAULT_RESTART, FAULT_BANG, FAULT_RANGE, FAULT_LEAD_ZERO,
        FAULT_EOL, FAULT_HIGH_BYTE, FAULT_COMMENT_HIGH, FAULT_RANGE_FIRST
    } t_fault;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mmts_in_if  in_bus ();
    mmts_out_if out_bus ();

    maximal_munch_token_scanner dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    token_checker tokens = new();
    t_src_byte    source_text [$];
    int unsigned  burst_left = 0;
    bit           prev_wordlike = 1'b0;
    int unsigned  stall_asked = 0;

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && in_bus.valid && in_bus.ready) begin
            tokens.note_byte(in_bus.ch, in_bus.line_end);
        end
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            tokens.check_token('{out_bus.kind, out_bus.num_value, out_bus.token_length,
                                 out_bus.error_code, out_bus.last});
        end
    end

    function automatic logic [7:0] pick_alnum(bit letters_only);
        int r;
        r = letters_only ? $urandom_range(0, 51) : $urandom_range(0, 61);
        if (r < 26) return 8'(8'h61 + r);
        if (r < 52) return 8'(8'h41 + r - 26);
        return 8'(8'h30 + r - 52);
    endfunction

    function automatic void append_text(ref logic [7:0] q [$], input string s);
        for (int i = 0; i < s.len(); i++) q.insert(q.size(), s[i]);
    endfunction

    task automatic add_text(string s, bit eol);
        for (int i = 0; i < s.len(); i++) begin
            source_text.insert(source_text.size(), '{s[i], eol && i == s.len() - 1});
        end
    endtask

    task automatic add_random_token(int idx);
        string       words [10] = '{"int", "wain", "if", "else", "while",
                                    "println", "return", "new", "delete", "NULL"};
        string       marks [21] = '{"(", ")", "{", "}", "[", "]", "=", "+", "-", "*", "/",
                                    "%", "&", ",", ";", "<", ">", "<=", ">=", "!=", "=="};
        logic [7:0]  blanks [4] = '{8'h20, 8'h09, 8'h0D, 8'h0A};
        logic [7:0]  tok [$];
        logic [7:0]  c;
        int          pick;
        int          n;
        int unsigned v;
        bit          eol;
        bit          wordlike;
        pick     = $urandom_range(0, 15);
        eol      = ($urandom_range(0, 5) == 0);
        wordlike = 1'b1;
        if (idx == 20 || idx == 90) begin
            n = (idx == 20) ? 255 : $urandom_range(256, 300);
            tok.insert(tok.size(), pick_alnum(1'b1));
            repeat (n - 1) tok.insert(tok.size(), pick_alnum(1'b0));
        end else if (pick < 3) begin
            tok.insert(tok.size(), pick_alnum(1'b1));
            repeat ($urandom_range(0, 9)) tok.insert(tok.size(), pick_alnum(1'b0));
        end else if (pick < 5) begin
            append_text(tok, words[$urandom_range(0, 9)]);
        end else if (pick < 6) begin
            append_text(tok, words[$urandom_range(0, 9)]);
            case ($urandom_range(0, 2))
                0:       tok.insert(tok.size(), pick_alnum(1'b0));
                1:       tok.delete(tok.size() - 1);
                default: tok[0] = tok[0] ^ 8'h20;
            endcase
        end else if (pick < 9) begin
            case ($urandom_range(0, 3))
                0:       v = $urandom_range(0, 9);
                1:       v = $urandom_range(0, 99999);
                2:       v = $urandom_range(0, 2147483647);
                default: v = 2147483647 - $urandom_range(0, 20);
            endcase
            append_text(tok, $sformatf("%0d", v));
        end else if (pick < 13) begin
            append_text(tok, marks[$urandom_range(0, 20)]);
            wordlike = 1'b0;
        end else if (pick < 15) begin
            repeat ($urandom_range(1, 4)) tok.insert(tok.size(), blanks[$urandom_range(0, 3)]);
            wordlike = 1'b0;
        end else begin
            append_text(tok, "//");
            repeat ($urandom_range(0, 12)) begin
                do c = 8'($urandom_range(0, 127)); while (c == 8'h0A || c == 8'h0D);
                tok.insert(tok.size(), c);
            end
            eol      = 1'b1;
            wordlike = 1'b0;
        end
        if (prev_wordlike && wordlike) source_text.insert(source_text.size(), '{8'h20, 1'b0});
        for (int i = 0; i < tok.size(); i++) begin
            source_text.insert(source_text.size(), '{tok[i], eol && i == tok.size() - 1});
        end
        prev_wordlike = wordlike && !eol;
    endtask

    task automatic add_fault();
        t_fault fault;
        fault = t_fault'($urandom_range(0, 8));
        add_text(" ", 1'b1);
        case (fault)
            FAULT_START:        add_text("#", 1'b0);
            FAULT_RESTART:      add_text("abc#", 1'b0);
            FAULT_BANG:         add_text("!x", 1'b0);
            FAULT_RANGE:        add_text("2147483648 ", 1'b0);
            FAULT_LEAD_ZERO:    add_text("007;", 1'b0);
            FAULT_EOL:          add_text("!", 1'b1);
            FAULT_HIGH_BYTE:    source_text.insert(source_text.size(),
                                                   '{8'($urandom_range(128, 255)), 1'b0});
            FAULT_COMMENT_HIGH: begin
                add_text("//ab", 1'b0);
                source_text.insert(source_text.size(), '{8'($urandom_range(128, 255)), 1'b0});
            end
            default:            add_text("02147483648;", 1'b0);
        endcase
        source_text.insert(source_text.size(), '{8'hFF, 1'b1});
        source_text.insert(source_text.size(), '{8'h00, 1'b0});
        repeat (20) begin
            source_text.insert(source_text.size(),
                               '{8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))});
        end
    endtask

    task automatic send_byte(t_src_byte b);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                       : $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_bus.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_bus.valid    <= 1'b1;
        in_bus.ch       <= b.ch;
        in_bus.line_end <= b.eol;
        do @(posedge i_clk); while (!in_bus.ready);
    endtask

    initial begin
        t_rx_mode    mode;
        int          mode_left;
        int          hold_left;
        int          phase;
        int unsigned stall_seen;
        mode          = RX_OPEN;
        mode_left     = 0;
        hold_left     = 0;
        phase         = 0;
        stall_seen    = 0;
        out_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_asked != stall_seen && hold_left == 0) begin
                hold_left = 300;
                stall_seen++;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_bus.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(40, 200);
                end
                mode_left--;
                phase++;
                case (mode)
                    RX_OPEN:  out_bus.ready <= 1'b1;
                    RX_COIN:  out_bus.ready <= 1'($urandom_range(0, 1));
                    RX_THIRD: out_bus.ready <= (phase % 3 == 0);
                    default:  out_bus.ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    initial begin
        int idx;
        in_bus.valid    <= 1'b0;
        in_bus.ch       <= 8'h00;
        in_bus.line_end <= 1'b0;
        i_rst_n         <= 1'b0;

        add_text("println 2147483647", 1'b1);
        add_text("a!=0;//z", 1'b1);
        add_text(" \t", 1'b1);
        idx = 0;
        while (source_text.size() < 850) begin
            add_random_token(idx);
            idx++;
        end
        add_fault();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int k = 0; k < source_text.size(); k++) begin
            if (k == 200 || k == 600) stall_asked <= stall_asked + 1;
            send_byte(source_text[k]);
        end
        in_bus.valid <= 1'b0;
        while (tokens.pending_tokens.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (tokens.mismatches == 0 && tokens.pending_tokens.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
